### hdl/spd_pkg.sv
// Shared types and constants of the stream packet deframer.
// Used by the front, back and top modules of the block; depends on nothing else.
package spd_pkg;

  // Register indexes of the configuration port.
  localparam logic CFG_FRAME_MODE = 1'b0;
  localparam logic CFG_MAX_BYTES  = 1'b1;

  // Framing modes. Code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_LENGTH = 2'd1,
    MODE_LINE   = 2'd2
  } frame_mode_e;

  localparam logic [7:0]  CHAR_CR         = 8'h0D;
  localparam logic [7:0]  CHAR_LF         = 8'h0A;
  localparam logic [2:0]  HEADER_BYTES    = 3'd4;
  localparam logic [31:0] MAX_BYTES_RESET = 32'd16777216;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int FIFO_DEPTH_DEFAULT  = 4;

  // One result item without its run marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       packet_end;
    logic       too_large;
  } res_t;

  // One queue entry: the results caused by one input byte.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic res_t data_res(input logic [7:0] b);
    res_t r;
    r            = '0;
    r.out_byte   = b;
    r.has_byte   = 1'b1;
    return r;
  endfunction

  function automatic res_t end_res();
    res_t r;
    r            = '0;
    r.packet_end = 1'b1;
    return r;
  endfunction

  function automatic res_t err_res();
    res_t r;
    r           = '0;
    r.too_large = 1'b1;
    return r;
  endfunction

endpackage

### hdl/spd_fifo.sv
// Small register queue between the front and back parts of the deframer.
// Generic in width and depth; needs no package.
module spd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");

endmodule

### hdl/spd_front.sv
// Front part of the deframer: accepts bytes, tracks framing and the
// configuration registers, and queues the results of each byte. Uses spd_pkg.
module spd_front #(
  parameter int LengthBits = spd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                full_i,
  output logic                push_o,
  output spd_pkg::entry_t     entry_o
);
  import spd_pkg::*;

  logic                  closed_q, closed_d;
  logic [1:0]            mode_q, mode_d;
  logic [31:0]           max_q, max_d;
  logic [2:0]            hdr_q, hdr_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [31:0]           cnt_q, cnt_d;
  logic                  cr_q, cr_d;

  logic                  accept;
  logic [LengthBits-1:0] len_next;
  logic [31:0]           len_ext;
  logic [31:0]           cnt_inc, cnt_dec;
  logic                  ovf0, ovf1;

  // A register write takes the cycle, so no byte is taken alongside it.
  assign rx_ready_o = !full_i && !cfg_we_i;
  assign accept     = rx_valid_i && rx_ready_o;

  assign len_next = LengthBits'({len_q, rx_byte_i});
  assign len_ext  = 32'(len_next);
  assign cnt_inc  = cnt_q + 32'd1;
  assign cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - 32'd1;
  // Line overflow checks for the first and the second data byte of a step.
  assign ovf0     = (cnt_q >= max_q);
  assign ovf1     = (cnt_inc >= max_q);

  always_comb begin
    closed_d = closed_q;
    mode_d   = mode_q;
    max_d    = max_q;
    hdr_d    = hdr_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    cr_d     = cr_q;
    push_o   = 1'b0;
    entry_o  = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_MODE: begin
          mode_d = cfg_data_i[1:0];
          hdr_d  = '0;
          len_d  = '0;
          cnt_d  = '0;
          cr_d   = 1'b0;
        end
        CFG_MAX_BYTES: begin
          if (cfg_data_i != '0) begin
            max_d = cfg_data_i;
          end
        end
        default: ;
      endcase
    end else if (accept && !closed_q) begin
      unique case (mode_q)
        MODE_RAW: begin
          push_o     = 1'b1;
          entry_o.r0 = data_res(rx_byte_i);
        end
        MODE_LENGTH: begin
          if (hdr_q < HEADER_BYTES) begin
            hdr_d = hdr_q + 3'd1;
            len_d = len_next;
            if (hdr_q == HEADER_BYTES - 3'd1) begin
              len_d = '0;
              if (len_ext > max_q) begin
                closed_d   = 1'b1;
                push_o     = 1'b1;
                entry_o.r0 = err_res();
              end else if (len_ext == '0) begin
                hdr_d      = '0;
                push_o     = 1'b1;
                entry_o.r0 = end_res();
              end else begin
                cnt_d = len_ext;
              end
            end
          end else begin
            cnt_d      = cnt_dec;
            push_o     = 1'b1;
            entry_o.r0 = data_res(rx_byte_i);
            if (cnt_dec == '0) begin
              hdr_d                 = '0;
              entry_o.r0.packet_end = 1'b1;
            end
          end
        end
        MODE_LINE: begin
          if (cr_q) begin
            cr_d   = 1'b0;
            push_o = 1'b1;
            if (rx_byte_i == CHAR_LF) begin
              cnt_d      = '0;
              entry_o.r0 = end_res();
            end else if (ovf0) begin
              closed_d   = 1'b1;
              entry_o.r0 = err_res();
            end else begin
              // The held CR turned out to be data.
              entry_o.r0 = data_res(CHAR_CR);
              cnt_d      = cnt_inc;
              if (rx_byte_i == CHAR_CR) begin
                cr_d = 1'b1;
              end else if (ovf1) begin
                closed_d    = 1'b1;
                entry_o.two = 1'b1;
                entry_o.r1  = err_res();
              end else begin
                entry_o.two = 1'b1;
                entry_o.r1  = data_res(rx_byte_i);
                cnt_d       = cnt_q + 32'd2;
              end
            end
          end else if (rx_byte_i == CHAR_CR) begin
            cr_d = 1'b1;
          end else if (ovf0) begin
            closed_d   = 1'b1;
            push_o     = 1'b1;
            entry_o.r0 = err_res();
          end else begin
            cnt_d      = cnt_inc;
            push_o     = 1'b1;
            entry_o.r0 = data_res(rx_byte_i);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
      mode_q   <= MODE_RAW;
      max_q    <= MAX_BYTES_RESET;
      hdr_q    <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      cr_q     <= 1'b0;
    end else begin
      closed_q <= closed_d;
      mode_q   <= mode_d;
      max_q    <= max_d;
      hdr_q    <= hdr_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      cr_q     <= cr_d;
    end
  end

  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> !push_o)
    else $error("result queued after the block closed");

  a_header_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.r0.too_large) |=> closed_q)
    else $error("error result did not close the block");

endmodule

### hdl/spd_back.sv
// Back part of the deframer: takes queue entries and delivers their one or
// two result items on the output channel. Uses spd_pkg.
module spd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spd_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            packet_end_o,
  output logic            too_large_o,
  output logic            run_last_o
);
  import spd_pkg::*;

  logic sel_q, sel_d;
  res_t cur;
  logic fire;

  assign cur          = sel_q ? head_i.r1 : head_i.r0;
  assign out_valid_o  = !empty_i;
  assign out_byte_o   = cur.out_byte;
  assign has_byte_o   = cur.has_byte;
  assign packet_end_o = cur.packet_end;
  assign too_large_o  = cur.too_large;
  assign run_last_o   = sel_q || !head_i.two;
  assign fire         = out_valid_o && out_ready_i;
  assign pop_o        = fire && run_last_o;

  always_comb begin
    sel_d = sel_q;
    if (fire) begin
      sel_d = !run_last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  a_second_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!empty_i && head_i.two))
    else $error("second result selected without a two-result entry");

endmodule

### hdl/stream_packet_deframer_top.sv
// Stream packet deframer: one received byte per item in, framed result items out.
// An accepted byte's results are registered in the result queue and offered from its head.
// One byte per cycle while the result queue has room and no register write is made;
// a byte that gives two results offers them in turn, so the rate is set by the consumer.
// Reset (async, active low): raw mode, limit 16777216 bytes, block open, queue empty.
// Depends on spd_pkg, spd_fifo, spd_front and spd_back.
module stream_packet_deframer_top #(
  parameter int LengthBits = spd_pkg::LENGTH_BITS_DEFAULT,
  parameter int FifoDepth  = spd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: index 0 is frame_mode, index 1 is max_packet_bytes.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Input byte stream.
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        packet_end_o,
  output logic        too_large_o,
  output logic        run_last_o
);
  import spd_pkg::*;

  // The front decides all framing state at acceptance time and writes the
  // results of each byte as one queue entry. Bytes that give no result (header
  // bytes but the last, a held CR, anything after an error) write nothing.
  logic   push, pop, empty, full;
  entry_t push_entry, head;

  spd_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // The queue lets the input keep flowing while the consumer stalls.
  spd_fifo #(
    .Width($bits(entry_t)),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  // The back walks through the one or two results of the head entry and
  // marks the last one of each byte with run_last.
  spd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .packet_end_o (packet_end_o),
    .too_large_o  (too_large_o),
    .run_last_o   (run_last_o)
  );

endmodule

### tb/sv/tb_spd_result_check.sv
// Result checker for the stream packet deframer testbench: watches the
// configuration port and both item channels, predicts every result item and
// compares it with what the block delivers. Depends on spd_pkg.
`timescale 1ns / 100ps

module tb_spd_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        has_byte_i,
  input  logic        packet_end_i,
  input  logic        too_large_i,
  input  logic        run_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import spd_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       packet_end;
    logic       too_large;
    logic       run_last;
  } frame_res_t;

  // Shadow copy of the configuration and framing state.
  logic [1:0]  mode_q;
  logic [31:0] limit_q;
  logic        closed_q;
  logic [2:0]  hdr_cnt_q;
  logic [31:0] len_acc_q;
  logic [31:0] frame_cnt_q;  // body bytes left, or data bytes in the current line
  logic        cr_held_q;

  frame_res_t expected_res_q[$];
  frame_res_t byte_res_q[$];  // results caused by the byte being processed
  frame_res_t got, want;

  function automatic frame_res_t make_res(input logic [7:0] b, input logic has,
                                          input logic fin, input logic err);
    frame_res_t r;
    r = {b, has, fin, err, 1'b0};
    return r;
  endfunction

  task automatic clear_framing();
    hdr_cnt_q   = '0;
    len_acc_q   = '0;
    frame_cnt_q = '0;
    cr_held_q   = 1'b0;
  endtask

  // One data byte of a line; an overflow closes the block instead.
  task automatic line_byte(input logic [7:0] c, output bit overflow);
    if (frame_cnt_q >= limit_q) begin
      closed_q = 1'b1;
      byte_res_q.push_back(make_res(8'h00, 1'b0, 1'b0, 1'b1));
      overflow = 1'b1;
    end else begin
      frame_cnt_q++;
      byte_res_q.push_back(make_res(c, 1'b1, 1'b0, 1'b0));
      overflow = 1'b0;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    bit         ovf;
    frame_res_t r;
    byte_res_q.delete();
    if (!closed_q) begin
      case (mode_q)
        MODE_RAW: byte_res_q.push_back(make_res(b, 1'b1, 1'b0, 1'b0));
        MODE_LENGTH: begin
          if (hdr_cnt_q < HEADER_BYTES) begin
            len_acc_q = {len_acc_q[23:0], b};
            hdr_cnt_q++;
            if (hdr_cnt_q == HEADER_BYTES) begin
              if (len_acc_q > limit_q) begin
                closed_q = 1'b1;
                byte_res_q.push_back(make_res(8'h00, 1'b0, 1'b0, 1'b1));
              end else if (len_acc_q == '0) begin
                hdr_cnt_q = '0;
                byte_res_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b0));
              end else begin
                frame_cnt_q = len_acc_q;
              end
              len_acc_q = '0;
            end
          end else begin
            if (frame_cnt_q != '0) frame_cnt_q--;
            if (frame_cnt_q == '0) hdr_cnt_q = '0;
            byte_res_q.push_back(make_res(b, 1'b1, frame_cnt_q == '0, 1'b0));
          end
        end
        MODE_LINE: begin
          if (cr_held_q) begin
            cr_held_q = 1'b0;
            if (b == CHAR_LF) begin
              frame_cnt_q = '0;
              byte_res_q.push_back(make_res(8'h00, 1'b0, 1'b1, 1'b0));
            end else begin
              // The held CR turned out to be data; it goes out first.
              line_byte(CHAR_CR, ovf);
              if (!ovf) begin
                if (b == CHAR_CR) cr_held_q = 1'b1;
                else line_byte(b, ovf);
              end
            end
          end else if (b == CHAR_CR) begin
            cr_held_q = 1'b1;
          end else begin
            line_byte(b, ovf);
          end
        end
        default: ;
      endcase
    end
    foreach (byte_res_q[i]) begin
      r = byte_res_q[i];
      r.run_last = (i == byte_res_q.size() - 1);
      expected_res_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = MODE_RAW;
      limit_q  = MAX_BYTES_RESET;
      closed_q = 1'b0;
      clear_framing();
      expected_res_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {out_byte_i, has_byte_i, packet_end_i, too_large_i, run_last_i};
        checked_o++;
        if (expected_res_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected result byte %02h has %b end %b err %b last %b",
                     $realtime, got.out_byte, got.has_byte, got.packet_end,
                     got.too_large, got.run_last);
          fail_count_o++;
        end else begin
          want = expected_res_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display({"%0t: result %0d: expected byte %02h has %b end %b err %b last %b,",
                        " got byte %02h has %b end %b err %b last %b"},
                       $realtime, checked_o, want.out_byte, want.has_byte,
                       want.packet_end, want.too_large, want.run_last, got.out_byte,
                       got.has_byte, got.packet_end, got.too_large, got.run_last);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_MODE) begin
          mode_q = cfg_data_i[1:0];
          clear_framing();
        end else if (cfg_data_i != '0) begin
          limit_q = cfg_data_i;
        end
      end
      if (rx_valid_i && rx_ready_i) deframe_byte(rx_byte_i);
      pending_o = expected_res_q.size();
    end
  end

endmodule

### tb/sv/tb_stream_packet_deframer_top.sv
// Top of the stream packet deframer testbench: clock, reset, configuration
// writes and the byte stream, plus the consumer of result items and the verdict.
// Depends on spd_pkg, stream_packet_deframer_top and tb_spd_result_check.
`timescale 1ns / 100ps

module tb_stream_packet_deframer_top;
  import spd_pkg::*;

  // Code 3 of frame_mode has no meaning; the block must ignore bytes under it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_data;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        packet_end;
  logic        too_large;
  logic        run_last;

  int fail_count;
  int pending;
  int checked;

  // Test state of the byte sender; idle_en and stall_req are also read by the result consumer.
  bit          idle_en;    // random idle bursts on both channels
  bit          stall_req;  // asks the consumer for one long hold-off
  int          items_sent;
  int          phases;
  logic [31:0] cur_limit;  // limit the block holds, for building legal packets
  logic [7:0]  stream_q[$];

  stream_packet_deframer_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .rx_valid_i   (rx_valid),
    .rx_ready_o   (rx_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .has_byte_o   (has_byte),
    .packet_end_o (packet_end),
    .too_large_o  (too_large),
    .run_last_o   (run_last)
  );

  tb_spd_result_check u_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .rx_valid_i   (rx_valid),
    .rx_ready_i   (rx_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .has_byte_i   (has_byte),
    .packet_end_i (packet_end),
    .too_large_i  (too_large),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net: the slowest legal run needs well under a tenth of this.
  initial begin
    #1_600_000;
    $display("Timeout with %0d results still expected.", pending);
    $display("tb_stream_packet_deframer_top NOT OK");
    $finish;
  end

  // Result consumer. It normally accepts every cycle, idles in short random
  // bursts while idling is enabled, and on request holds off for a long
  // stretch so that the result queue fills and the block stalls its input.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (100) @(posedge clk);
        stall_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one byte and returns at the edge that accepts it. Valid stays high
  // from one item to the next unless an idle burst is taken first.
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i]);
    stream_q.delete();
  endtask

  // Stops sending and waits until every expected result has been taken.
  // The status is read at the falling edge so it is settled. The extra
  // cycles cover bytes that are still in flight but cause no result.
  task automatic drain_results();
    rx_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on an idle block. The limit goes first; a zero
  // limit must be ignored by the block. The mode write restarts framing.
  task automatic set_regs(input logic [1:0] mode, input logic [31:0] limit);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAX_BYTES;
    cfg_data <= limit;
    @(posedge clk);
    cfg_idx  <= CFG_FRAME_MODE;
    cfg_data <= {30'd0, mode};
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (limit != '0) cur_limit = limit;
    phases++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHAR_CR || b == CHAR_LF) b = 8'h5A;
    return b;
  endfunction

  // A length-prefixed packet whose body never exceeds the current limit.
  task automatic queue_length_packet();
    logic [31:0] plen;
    plen = $urandom_range(0, (cur_limit < 12) ? cur_limit : 12);
    for (int i = 3; i >= 0; i--) stream_q.push_back(plen[8*i +: 8]);
    repeat (plen) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // A CR LF terminated line. Stray CRs and LFs in the content can only end
  // the line early or count as data, so the line never overflows the limit.
  task automatic queue_line();
    int n;
    int pick;
    n = $urandom_range(0, (cur_limit < 10) ? cur_limit : 10);
    repeat (n) begin
      pick = $urandom_range(0, 11);
      if (pick < 2) stream_q.push_back(CHAR_CR);
      else if (pick == 2) stream_q.push_back(CHAR_LF);
      else stream_q.push_back(8'($urandom_range(0, 255)));
    end
    stream_q.push_back(CHAR_CR);
    stream_q.push_back(CHAR_LF);
  endtask

  // Well-formed packets or lines with random content. Half of the phases are
  // cut at the budget, which leaves a packet or line broken off when the next
  // mode write restarts framing.
  task automatic stream_phase(input logic [1:0] mode, input int budget);
    while (stream_q.size() < budget) begin
      case (mode)
        MODE_LENGTH: queue_length_packet();
        MODE_LINE:   queue_line();
        default:     stream_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 1) == 1)
      while (stream_q.size() > budget) void'(stream_q.pop_back());
    send_stream();
  endtask

  initial begin
    int          kind;
    int          lim;
    int          waited;
    logic [1:0]  mode_pick;
    logic [31:0] limit_pick;
    logic [31:0] plen;
    string       close_case;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_FRAME_MODE;
    cfg_data   <= '0;
    rx_valid   <= 1'b0;
    rx_byte    <= '0;
    idle_en    = 1'b1;
    stall_req  = 1'b0;
    items_sent = 0;
    phases     = 0;
    cur_limit  = MAX_BYTES_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Raw mode straight out of reset, including the framing characters.
    stream_q.push_back(8'h00); stream_q.push_back(8'hFF);
    stream_q.push_back(CHAR_CR); stream_q.push_back(CHAR_LF);
    send_stream();

    // Length mode: a zero length gives a bare end marker, a body exactly at
    // the limit, and a one-byte body.
    set_regs(MODE_LENGTH, 32'd5);
    repeat (4) stream_q.push_back(8'h00);
    repeat (3) stream_q.push_back(8'h00);
    stream_q.push_back(8'h05);
    stream_q.push_back(8'h11); stream_q.push_back(8'h22); stream_q.push_back(8'h33);
    stream_q.push_back(8'h44); stream_q.push_back(8'h55);
    repeat (3) stream_q.push_back(8'h00);
    stream_q.push_back(8'h01); stream_q.push_back(8'hA5);
    send_stream();

    // Line mode with a limit of three: a full line whose CR is held at the
    // limit, a CR followed by a CR, and a held CR released by a data byte,
    // which gives two results for one byte.
    set_regs(MODE_LINE, 32'd3);
    stream_q.push_back(8'h61); stream_q.push_back(8'h62); stream_q.push_back(8'h63);
    stream_q.push_back(CHAR_CR); stream_q.push_back(CHAR_LF);
    stream_q.push_back(CHAR_CR); stream_q.push_back(CHAR_CR); stream_q.push_back(CHAR_LF);
    stream_q.push_back(8'h71); stream_q.push_back(CHAR_CR); stream_q.push_back(8'h7A);
    stream_q.push_back(CHAR_CR); stream_q.push_back(CHAR_LF);
    send_stream();

    // The unused mode code: bytes are swallowed without results.
    set_regs(MODE_UNUSED, 32'd3);
    stream_q.push_back(8'h0D); stream_q.push_back(8'hF0);
    send_stream();

    // Random phases over every mode and a spread of limits, the extremes and
    // an ignored zero write among them. The fourth random phase carries the long
    // consumer hold-off; the closing stretch runs without idling.
    while (items_sent < 640) begin
      idle_en = (items_sent < 540);
      case ($urandom_range(0, 9))
        0, 1:       mode_pick = MODE_RAW;
        2, 3, 4, 5: mode_pick = MODE_LENGTH;
        default:    mode_pick = MODE_LINE;
      endcase
      if (phases % 7 == 3) mode_pick = MODE_UNUSED;
      if (phases == 6) mode_pick = MODE_RAW;
      case ($urandom_range(0, 7))
        0:       limit_pick = 32'd1;
        1:       limit_pick = 32'hFFFF_FFFF;
        2:       limit_pick = '0;
        3:       limit_pick = MAX_BYTES_RESET;
        default: limit_pick = $urandom_range(1, 12);
      endcase
      set_regs(mode_pick, limit_pick);
      if (phases == 7) stall_req = 1'b1;
      stream_phase(mode_pick, $urandom_range(20, 60));
    end

    // Close the block with one overflow case, picked at random: a length
    // header above the limit, a line running past the limit, a held CR that
    // turns out to be data on a full line, or a CR released together with a
    // byte that then overflows.
    kind = $urandom_range(0, 3);
    lim  = $urandom_range(1, 6);
    if (kind == 0) begin
      close_case = "length header over the limit";
      set_regs(MODE_LENGTH, lim);
      plen = $urandom;
      if (plen <= lim) plen = lim + 1;
      for (int i = 3; i >= 0; i--) stream_q.push_back(plen[8*i +: 8]);
    end else begin
      set_regs(MODE_LINE, lim);
      repeat ((kind == 3) ? lim - 1 : lim) stream_q.push_back(plain_byte());
      if (kind == 1) begin
        close_case = "line data over the limit";
      end else begin
        close_case = (kind == 2) ? "held CR on a full line" : "CR and data past the limit";
        stream_q.push_back(CHAR_CR);
      end
      stream_q.push_back(plain_byte());
    end
    send_stream();

    // A closed block ignores everything, also after a mode change.
    repeat (12) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream();
    set_regs(MODE_RAW, 32'd16);
    repeat (6) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream();

    rx_valid <= 1'b0;
    waited = 0;
    @(negedge clk);
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived.", pending);

    $display("Sent %0d bytes over %0d configurations of raw, length, line and unused modes;",
             items_sent, phases);
    $display("checked %0d results, closed by the %s case.", checked, close_case);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_stream_packet_deframer_top OK");
    end else begin
      $display("tb_stream_packet_deframer_top NOT OK");
    end
    $finish;
  end

endmodule
